>>> rtl/core/three_address_vm_executor_assert.svh
// Assertion helpers for the executor core.
`ifndef THREE_ADDRESS_VM_EXECUTOR_ASSERT_SVH
`define THREE_ADDRESS_VM_EXECUTOR_ASSERT_SVH

// Same-cycle implication, checked on clk, masked while rst_n is low.
`define TAVM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on clk, masked while rst_n is low.
`define TAVM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/tavm_pkg.sv
// ----------------------------------------------------------------------------
// tavm_pkg
// Shared types and constants of the three-address VM executor.
// ----------------------------------------------------------------------------
package tavm_pkg;

    localparam int DATA_AW = 12;
    localparam int DATA_DEPTH = 1 << DATA_AW;
    localparam int PC_W = 12;
    localparam int WORD_W = 32;
    localparam int KIND_W = 5;
    localparam int OPND_W = 13;

    typedef logic [WORD_W-1:0] word_t;
    typedef logic [DATA_AW-1:0] daddr_t;
    typedef logic [PC_W-1:0] pc_t;

    typedef enum logic [KIND_W-1:0] {
        OP_ADDBX = 5'd0, OP_SETBX = 5'd1, OP_RET = 5'd2, OP_CALL = 5'd3,
        OP_UMINUS = 5'd4, OP_OUT = 5'd5, OP_IN = 5'd6, OP_NOT = 5'd7,
        OP_AND = 5'd8, OP_OR = 5'd9, OP_JNE = 5'd10, OP_JEQ = 5'd11,
        OP_JGE = 5'd12, OP_JGT = 5'd13, OP_JLE = 5'd14, OP_JLT = 5'd15,
        OP_NOP = 5'd16, OP_MOD = 5'd17, OP_DIV = 5'd18, OP_MUL = 5'd19,
        OP_SUB = 5'd20, OP_ADD = 5'd21, OP_INIT = 5'd22, OP_MOV = 5'd23,
        OP_JMP = 5'd24, OP_JTRUE = 5'd25, OP_JFALSE = 5'd26
    } op_t;

    typedef enum logic [1:0] {
        ST_OK = 2'd0, ST_UNSUPPORTED = 2'd1, ST_UNKNOWN = 2'd2, ST_DIV_ZERO = 2'd3
    } status_t;

    typedef struct packed {
        logic  start;
        word_t dividend;
        word_t divisor;
    } div_req_t;

    typedef struct packed {
        logic  done;
        word_t quotient;
        word_t remainder;
    } div_rsp_t;

endpackage

>>> rtl/core/tavm_ifs.sv
// ----------------------------------------------------------------------------
// tavm_ifs
// Valid/ready channels of the executor: instruction, result, configuration.
// ----------------------------------------------------------------------------
interface tavm_in_if;
    logic               valid;
    logic               ready;
    logic [4:0]         kind;
    logic signed [12:0] first_operand;
    logic signed [31:0] second_operand;
    logic signed [12:0] third_operand;
    logic signed [31:0] read_value;
    modport source (output valid, kind, first_operand, second_operand,
                    third_operand, read_value, input ready);
    modport sink (input valid, kind, first_operand, second_operand,
                  third_operand, read_value, output ready);
endinterface

interface tavm_out_if;
    logic               valid;
    logic               ready;
    logic [11:0]        next_pc;
    logic               halted;
    logic               out_valid;
    logic signed [31:0] out_value;
    logic [1:0]         status;
    modport source (output valid, next_pc, halted, out_valid, out_value, status,
                    input ready);
    modport sink (input valid, next_pc, halted, out_valid, out_value, status,
                  output ready);
endinterface

interface tavm_cfg_if;
    logic        valid;
    logic        ready;
    logic [11:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

>>> rtl/core/three_address_vm_executor.sv
// ----------------------------------------------------------------------------
// three_address_vm_executor
// Executes one three-address instruction per item against a local data memory.
// ----------------------------------------------------------------------------
//  channel | dir | payload                                           | accept
//  instr   | in  | kind, first/second/third_operand, read_value      | valid & ready
//  res     | out | next_pc, halted, out_valid, out_value, status     | valid & ready
//  cfg     | in  | data (halt_pc)                                    | valid & ready
//
//  After reset the data memory is zeroed by a sweep over all 4096 words, one
//  word per cycle; instr.ready stays low until it ends (cfg is taken throughout).
//  An item passes the states accept, address/read, execute and commit; div
//  and mod with a nonzero divisor also wait on the bit-serial divider.
//  One item is in flight at a time; the result sits in an output register,
//  so the next item may be accepted while res is stalled. Commit waits for
//  that register to drain.
// ----------------------------------------------------------------------------
module three_address_vm_executor
    import tavm_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    tavm_in_if.sink    instr,
    tavm_out_if.source res,
    tavm_cfg_if.sink   cfg
);

`include "three_address_vm_executor_assert.svh"

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_ADDR, S_EXEC, S_DIV, S_FIN
    } state_t;

    state_t   state_reg, state_next;
    daddr_t   clr_reg, clr_next;
    pc_t      pc_reg, pc_next;
    daddr_t   fb_reg, fb_next;
    pc_t      halt_reg, halt_next;

    // latched instruction
    logic [KIND_W-1:0] kind_reg;
    logic [OPND_W-1:0] f_reg, t_reg;
    word_t             s_reg, rv_reg;

    // execute results awaiting commit
    pc_t     npc_reg, npc_next;
    daddr_t  fbn_reg, fbn_next;
    status_t st_reg, st_next;
    logic    ov_reg, ov_next;
    word_t   outv_reg, outv_next;
    logic    we_reg, we_next;
    daddr_t  wa_reg, wa_next;
    word_t   wd_reg, wd_next;

    // output register
    logic    rv_valid_reg, rv_valid_next;
    pc_t     r_pc_reg;
    logic    r_halt_reg, r_ov_reg;
    word_t   r_val_reg;
    status_t r_st_reg;

    daddr_t   a1, a2, ad, raddr0, raddr1, waddr;
    word_t    x, y, wdata;
    logic     mem_we, fin_go, take;
    div_req_t div_req;
    div_rsp_t div_rsp;
    pc_t      target;

    // Operand offset to data address: negative means global slot -offset.
    assign a1 = f_reg[OPND_W-1] ? DATA_AW'(-f_reg) : fb_reg + f_reg[DATA_AW-1:0];
    assign a2 = s_reg[WORD_W-1] ? DATA_AW'(-s_reg) : fb_reg + s_reg[DATA_AW-1:0];
    assign ad = t_reg[OPND_W-1] ? DATA_AW'(-t_reg) : fb_reg + t_reg[DATA_AW-1:0];
    assign target = t_reg[PC_W-1:0];

    // ret reads the frame header: saved delta at fb, return pc at fb+1
    assign raddr0 = (kind_reg == OP_RET) ? fb_reg : a1;
    assign raddr1 = (kind_reg == OP_RET) ? fb_reg + 1'b1 : a2;

    assign fin_go = (state_reg == S_FIN) && (!rv_valid_reg || res.ready);
    assign mem_we = (state_reg == S_CLEAR) || (fin_go && we_reg);
    assign waddr  = (state_reg == S_CLEAR) ? clr_reg : wa_reg;
    assign wdata  = (state_reg == S_CLEAR) ? '0 : wd_reg;

    tavm_dmem u_dmem (
        .clk    (clk),
        .we     (mem_we),
        .waddr  (waddr),
        .wdata  (wdata),
        .raddr0 (raddr0),
        .raddr1 (raddr1),
        .rdata0 (x),
        .rdata1 (y)
    );

    assign div_req.start    = (state_reg == S_EXEC) && (y != '0)
                              && (kind_reg == OP_DIV || kind_reg == OP_MOD);
    assign div_req.dividend = x;
    assign div_req.divisor  = y;

    tavm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // branch condition (signed compare)
    always_comb
    begin
        case (kind_reg)
            OP_JNE:    take = x != y;
            OP_JEQ:    take = x == y;
            OP_JGE:    take = $signed(x) >= $signed(y);
            OP_JGT:    take = $signed(x) > $signed(y);
            OP_JLE:    take = $signed(x) <= $signed(y);
            OP_JLT:    take = $signed(x) < $signed(y);
            OP_JMP:    take = 1'b1;
            OP_JTRUE:  take = x != '0;
            OP_JFALSE: take = x == '0;
            default:   take = 1'b0;
        endcase
    end

    assign instr.ready = (state_reg == S_IDLE);
    assign cfg.ready   = 1'b1;

    always_comb
    begin
        state_next    = state_reg;
        clr_next      = clr_reg;
        pc_next       = pc_reg;
        fb_next       = fb_reg;
        halt_next     = cfg.valid ? cfg.data : halt_reg;
        npc_next      = npc_reg;
        fbn_next      = fbn_reg;
        st_next       = st_reg;
        ov_next       = ov_reg;
        outv_next     = outv_reg;
        we_next       = we_reg;
        wa_next       = wa_reg;
        wd_next       = wd_reg;
        rv_valid_next = res.ready ? 1'b0 : rv_valid_reg;
        case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == '1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (instr.valid)
                begin
                    state_next = S_ADDR;
                end
            end
            S_ADDR:
            begin
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                npc_next  = take ? target : pc_reg + 1'b1;
                fbn_next  = fb_reg;
                st_next   = ST_OK;
                ov_next   = 1'b0;
                outv_next = '0;
                we_next   = 1'b0;
                wa_next   = ad;
                wd_next   = '0;
                state_next = S_FIN;
                case (kind_reg)
                    OP_ADDBX:  fbn_next = fb_reg + f_reg[DATA_AW-1:0];
                    OP_SETBX:  fbn_next = f_reg[DATA_AW-1:0];
                    OP_RET:
                    begin
                        fbn_next = fb_reg - x[DATA_AW-1:0];
                        npc_next = y[PC_W-1:0];
                    end
                    OP_CALL:   npc_next = f_reg[PC_W-1:0];
                    OP_UMINUS:
                    begin
                        we_next = 1'b1;
                        wd_next = -x;
                    end
                    OP_OUT:
                    begin
                        ov_next   = 1'b1;
                        outv_next = x;
                    end
                    OP_IN:
                    begin
                        we_next = 1'b1;
                        wa_next = a1;
                        wd_next = rv_reg;
                    end
                    OP_NOT, OP_AND, OP_OR: st_next = ST_UNSUPPORTED;
                    OP_MOD, OP_DIV:
                    begin
                        we_next = 1'b1;
                        if (y == '0)
                        begin
                            st_next = ST_DIV_ZERO;
                        end
                        else
                        begin
                            state_next = S_DIV;
                        end
                    end
                    OP_MUL:
                    begin
                        we_next = 1'b1;
                        wd_next = x * y;
                    end
                    OP_SUB:
                    begin
                        we_next = 1'b1;
                        wd_next = x - y;
                    end
                    OP_ADD:
                    begin
                        we_next = 1'b1;
                        wd_next = x + y;
                    end
                    OP_INIT:
                    begin
                        we_next = 1'b1;
                        wa_next = a1;
                        wd_next = s_reg;
                    end
                    OP_MOV:
                    begin
                        we_next = 1'b1;
                        wa_next = a1;
                        wd_next = y;
                    end
                    OP_JNE, OP_JEQ, OP_JGE, OP_JGT, OP_JLE, OP_JLT,
                    OP_NOP, OP_JMP, OP_JTRUE, OP_JFALSE: ;
                    default:
                    begin
                        st_next  = ST_UNKNOWN;
                        npc_next = pc_reg;
                    end
                endcase
            end
            S_DIV:
            begin
                if (div_rsp.done)
                begin
                    wd_next    = (kind_reg == OP_MOD) ? div_rsp.remainder : div_rsp.quotient;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (fin_go)
                begin
                    pc_next       = npc_reg;
                    fb_next       = fbn_reg;
                    rv_valid_next = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            clr_reg      <= '0;
            pc_reg       <= '0;
            fb_reg       <= '0;
            halt_reg     <= '1;
            rv_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            clr_reg      <= clr_next;
            pc_reg       <= pc_next;
            fb_reg       <= fb_next;
            halt_reg     <= halt_next;
            rv_valid_reg <= rv_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (instr.valid && instr.ready)
        begin
            kind_reg <= instr.kind;
            f_reg    <= instr.first_operand;
            s_reg    <= instr.second_operand;
            t_reg    <= instr.third_operand;
            rv_reg   <= instr.read_value;
        end
        npc_reg  <= npc_next;
        fbn_reg  <= fbn_next;
        st_reg   <= st_next;
        ov_reg   <= ov_next;
        outv_reg <= outv_next;
        we_reg   <= we_next;
        wa_reg   <= wa_next;
        wd_reg   <= wd_next;
        if (fin_go)
        begin
            r_pc_reg   <= npc_reg;
            r_halt_reg <= (npc_reg == halt_reg);
            r_ov_reg   <= ov_reg;
            r_val_reg  <= outv_reg;
            r_st_reg   <= st_reg;
        end
    end

    assign res.valid     = rv_valid_reg;
    assign res.next_pc   = r_pc_reg;
    assign res.halted    = r_halt_reg;
    assign res.out_valid = r_ov_reg;
    assign res.out_value = r_val_reg;
    assign res.status    = r_st_reg;

    `TAVM_ASSERT_NOW(a_no_accept_in_clear, state_reg == S_CLEAR, !instr.ready, "accept in clear")
    `TAVM_ASSERT_NOW(a_div_done_in_div, div_rsp.done, state_reg == S_DIV, "stray divider done")
    `TAVM_ASSERT_NEXT(a_commit_result, fin_go, res.valid && state_reg == S_IDLE, "no result")
    `TAVM_ASSERT_NEXT(a_pc_only_on_commit, !fin_go, $stable(pc_reg), "pc moved without commit")

endmodule

>>> rtl/core/tavm_dmem.sv
// ----------------------------------------------------------------------------
// tavm_dmem
// Data memory: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module tavm_dmem
    import tavm_pkg::*;
(
    input  logic   clk,
    input  logic   we,
    input  daddr_t waddr,
    input  word_t  wdata,
    input  daddr_t raddr0,
    input  daddr_t raddr1,
    output word_t  rdata0,
    output word_t  rdata1
);

    word_t mem [DATA_DEPTH];
    word_t rdata0_reg;
    word_t rdata1_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata0_reg <= mem[raddr0];
        rdata1_reg <= mem[raddr1];
    end

    assign rdata0 = rdata0_reg;
    assign rdata1 = rdata1_reg;

endmodule

>>> rtl/core/tavm_div.sv
// ----------------------------------------------------------------------------
// tavm_div
// Signed divider, restoring, one quotient bit per cycle; truncating.
// ----------------------------------------------------------------------------
module tavm_div
    import tavm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam int CNT_W = $clog2(WORD_W);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    word_t            quot_reg;
    word_t            rem_reg;
    word_t            dv_reg;
    logic             negq_reg;
    logic             negr_reg;
    logic [WORD_W:0]  shifted;
    logic [WORD_W:0]  trial;

    assign shifted = {rem_reg, quot_reg[WORD_W-1]};
    assign trial   = shifted - {1'b0, dv_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(WORD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quot_reg <= req.dividend[WORD_W-1] ? -req.dividend : req.dividend;
            dv_reg   <= req.divisor[WORD_W-1] ? -req.divisor : req.divisor;
            rem_reg  <= '0;
            negq_reg <= req.dividend[WORD_W-1] ^ req.divisor[WORD_W-1];
            negr_reg <= req.dividend[WORD_W-1];
        end
        else if (busy_reg)
        begin
            if (!trial[WORD_W])
            begin
                rem_reg  <= trial[WORD_W-1:0];
                quot_reg <= {quot_reg[WORD_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= shifted[WORD_W-1:0];
                quot_reg <= {quot_reg[WORD_W-2:0], 1'b0};
            end
        end
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = negq_reg ? -quot_reg : quot_reg;
    assign rsp.remainder = negr_reg ? -rem_reg : rem_reg;

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the three-address VM executor. A local model keeps
// its own data memory, pc, frame base and halt pc, and predicts one result
// item per instruction item. Directed tests cover every opcode and corner,
// then random programs, most with random stalls, and one long result hold-off.
// ----------------------------------------------------------------------------
module tb;
    import tavm_pkg::*;

    logic clk;
    logic rst_n;

    tavm_in_if  instr ();
    tavm_out_if res ();
    tavm_cfg_if cfg ();

    three_address_vm_executor u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .instr (instr),
        .res   (res),
        .cfg   (cfg)
    );

    // Expected result item.
    typedef struct {
        logic [11:0] next_pc;
        logic        halted;
        logic        out_valid;
        logic [31:0] out_value;
        logic [1:0]  status;
    } vm_result_t;

    // Model state of the executor.
    logic [31:0] mdl_mem [DATA_DEPTH];
    logic [11:0] mdl_pc;
    logic [11:0] mdl_frame;
    logic [11:0] mdl_halt_pc;

    vm_result_t result_queue[$];
    int         error_count;
    int         result_count;
    int         item_count;
    longint     cycle_count;
    bit         idle_enable;   // random bursts of idling on both sides
    bit         hold_results;  // long result hold-off requested
    int         hold_cycles;

    // Clock: period 8.
    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Watchdog: covers the reset sweep and every item plus idling.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Operand offset to data address: negative means global -offset.
    function automatic logic [11:0] resolve_addr(logic [31:0] off);
        logic [31:0] neg_off;
        neg_off = -off;
        if (off[31])
            return neg_off[11:0];
        return mdl_frame + off[11:0];
    endfunction

    // Execute one instruction on the model and queue its result.
    task automatic predict_instr(logic [4:0] kind, logic [12:0] f, logic [31:0] s,
                                 logic [12:0] t, logic [31:0] rd);
        vm_result_t  r;
        logic [11:0] a1;
        logic [11:0] a2;
        logic [11:0] ad;
        logic [11:0] npc;
        logic [11:0] old;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [31:0] q;
        logic [31:0] m;
        bit          take;
        a1 = resolve_addr({{19{f[12]}}, f});
        a2 = resolve_addr(s);
        ad = resolve_addr({{19{t[12]}}, t});
        x = mdl_mem[a1];
        y = mdl_mem[a2];
        npc = mdl_pc + 12'd1;
        r.out_valid = 1'b0;
        r.out_value = '0;
        r.status = ST_OK;
        take = 0;
        case (kind)
            OP_ADDBX: mdl_frame = mdl_frame + f[11:0];
            OP_SETBX: mdl_frame = f[11:0];
            OP_RET:
            begin
                old = mdl_frame;
                mdl_frame = old - mdl_mem[old][11:0];
                npc = mdl_mem[old + 12'd1][11:0];
            end
            OP_CALL:   npc = f[11:0];
            OP_UMINUS: mdl_mem[ad] = -x;
            OP_OUT:
            begin
                r.out_valid = 1'b1;
                r.out_value = x;
            end
            OP_IN:  mdl_mem[a1] = rd;
            OP_NOT, OP_AND, OP_OR: r.status = ST_UNSUPPORTED;
            OP_JNE: take = x != y;
            OP_JEQ: take = x == y;
            OP_JGE: take = x >= y;
            OP_JGT: take = x > y;
            OP_JLE: take = x <= y;
            OP_JLT: take = x < y;
            OP_NOP: ;
            OP_MOD, OP_DIV:
            begin
                if (y == 0)
                begin
                    mdl_mem[ad] = '0;
                    r.status = ST_DIV_ZERO;
                end
                else if (x == 32'sh80000000 && y == -1)
                    mdl_mem[ad] = (kind == OP_DIV) ? 32'h80000000 : 32'h0;
                else
                begin
                    q = x / y;
                    m = x % y;
                    mdl_mem[ad] = (kind == OP_DIV) ? q : m;
                end
            end
            OP_MUL:    mdl_mem[ad] = x * y;
            OP_SUB:    mdl_mem[ad] = x - y;
            OP_ADD:    mdl_mem[ad] = x + y;
            OP_INIT:   mdl_mem[a1] = s;
            OP_MOV:    mdl_mem[a1] = y;
            OP_JMP:    take = 1;
            OP_JTRUE:  take = x != 0;
            OP_JFALSE: take = x == 0;
            default:
            begin
                r.status = ST_UNKNOWN;
                npc = mdl_pc;
            end
        endcase
        if (take)
            npc = t[11:0];
        mdl_pc = npc;
        r.next_pc = npc;
        r.halted = (npc == mdl_halt_pc);
        result_queue.push_back(r);
    endtask

    // Send one instruction item, predict it on acceptance. valid stays up
    // after acceptance; the next item replaces it, an idle gap or the drain drops it.
    task automatic send_instr(logic [4:0] kind, logic [12:0] f, logic [31:0] s,
                              logic [12:0] t, logic [31:0] rd = '0);
        if (idle_enable && $urandom_range(0, 3) == 0)
        begin
            instr.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clk);
        end
        instr.valid <= 1'b1;
        instr.kind <= kind;
        instr.first_operand <= f;
        instr.second_operand <= s;
        instr.third_operand <= t;
        instr.read_value <= rd;
        @(posedge clk);
        while (!instr.ready)
            @(posedge clk);
        predict_instr(kind, f, s, t, rd);
        item_count++;
        @(negedge clk);
    endtask

    // Write halt_pc; only called with nothing in flight.
    task automatic write_halt_pc(logic [11:0] value);
        cfg.valid <= 1'b1;
        cfg.data <= value;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        mdl_halt_pc = value;
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    task automatic drain_results();
        instr.valid <= 1'b0;
        while (result_queue.size() != 0)
            @(negedge clk);
        repeat (45) @(negedge clk);
    endtask

    // Result sink: random stall bursts, or a long hold-off when asked.
    initial
    begin
        res.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_results && hold_cycles > 0)
            begin
                res.ready <= 1'b0;
                hold_cycles--;
            end
            else if (idle_enable && $urandom_range(0, 5) == 0)
            begin
                res.ready <= 1'b0;
                repeat ($urandom_range(1, 6) - 1) @(negedge clk);
            end
            else
                res.ready <= 1'b1;
        end
    end

    // Result checker.
    always @(posedge clk)
    begin
        vm_result_t e;
        if (rst_n && res.valid && res.ready)
        begin
            if (result_queue.size() == 0)
            begin
                $display("%0t: unexpected result item next_pc=%0d", $time, res.next_pc);
                error_count++;
            end
            else
            begin
                e = result_queue.pop_front();
                result_count++;
                if (res.next_pc !== e.next_pc || res.halted !== e.halted
                    || res.out_valid !== e.out_valid || res.out_value !== e.out_value
                    || res.status !== e.status)
                begin
                    $display("%0t: mismatch exp pc=%0d h=%0b ov=%0b val=%h st=%0d",
                             $time, e.next_pc, e.halted, e.out_valid, e.out_value,
                             e.status);
                    $display("%0t:          act pc=%0d h=%0b ov=%0b val=%h st=%0d",
                             $time, res.next_pc, res.halted, res.out_valid,
                             res.out_value, res.status);
                    error_count++;
                end
            end
        end
    end

    // Every opcode, including unsupported and unknown ones.
    task automatic test_all_opcodes();
        send_instr(OP_INIT, -13'sd10, 32'sd7, 0);
        send_instr(OP_INIT, -13'sd11, -32'sd3, 0);
        send_instr(OP_INIT, -13'sd12, 32'sd0, 0);
        for (int k = 0; k < 32; k++)
            send_instr(k[4:0], -13'sd10, -32'sd11, -13'sd20, 32'h1234);
        drain_results();
    endtask

    // Field extremes, divide corners, frame and pc wrap, ret.
    task automatic test_corners();
        send_instr(OP_INIT, -13'sd1, 32'h80000000, 0);
        send_instr(OP_INIT, -13'sd2, 32'hffffffff, 0);
        send_instr(OP_DIV, -13'sd1, -32'sd2, -13'sd3);
        send_instr(OP_MOD, -13'sd1, -32'sd2, -13'sd4);
        send_instr(OP_DIV, -13'sd1, -32'sd5, -13'sd3);   // divide by zero
        send_instr(OP_MOD, -13'sd2, -32'sd5, -13'sd3);
        send_instr(OP_OUT, -13'sd3, 0, 0);
        send_instr(OP_IN, 13'sd4095, 0, 0, 32'h7fffffff);
        send_instr(OP_IN, -13'sd4096, 0, 0, 32'h80000000);
        send_instr(OP_OUT, -13'sd4096, 0, 0);
        send_instr(OP_SETBX, -13'sd4096, 0, 0);
        send_instr(OP_ADDBX, 13'sd4095, 0, 0);
        send_instr(OP_CALL, -13'sd1, 0, 0);               // pc wrap upward
        send_instr(OP_JMP, 0, 0, 13'sd4095);
        send_instr(OP_NOP, 0, 0, 0);                      // increment wraps
        send_instr(OP_SETBX, 13'sd100, 0, 0);
        send_instr(OP_INIT, 13'sd0, 32'sd5, 0);
        send_instr(OP_INIT, 13'sd1, -32'sd2, 0);          // ret to negative pc
        send_instr(OP_RET, 0, 0, 0);
        send_instr(OP_MOV, 13'sd5, 32'h7fffffff, 0);
        drain_results();
    endtask

    function automatic logic [4:0] kind_pick();
        int p;
        p = $urandom_range(0, 99);
        if (p < 5)
            return 5'($urandom_range(27, 31));
        if (p < 12)
            return OP_RET;
        if (p < 25)
            return OP_INIT;
        return 5'($urandom_range(0, 26));
    endfunction

    // Random instruction; operands mostly in a small window to reuse data.
    task automatic send_random_instr();
        logic [4:0]  kind;
        logic [12:0] f;
        logic [12:0] t;
        logic [31:0] s;
        kind = (kind_pick()) ;
        f = ($urandom_range(0, 7) == 0) ? 13'($urandom) : 13'($urandom_range(0, 40) - 20);
        t = ($urandom_range(0, 7) == 0) ? 13'($urandom) : 13'($urandom_range(0, 40) - 20);
        s = ($urandom_range(0, 7) == 0) ? $urandom : 32'($urandom_range(0, 40) - 20);
        if (kind == OP_INIT && $urandom_range(0, 1))
            s = $urandom;
        send_instr(kind, f, s, t, $urandom);
    endtask

    task automatic test_random(int count);
        for (int i = 0; i < count; i++)
            send_random_instr();
        drain_results();
    endtask

    // Long result hold-off while instructions keep coming.
    task automatic test_backpressure();
        hold_cycles = 300;
        hold_results = 1;
        for (int i = 0; i < 20; i++)
            send_random_instr();
        hold_results = 0;
        drain_results();
    endtask

    initial
    begin
        rst_n = 1'b0;
        instr.valid = 1'b0;
        instr.kind = '0;
        instr.first_operand = '0;
        instr.second_operand = '0;
        instr.third_operand = '0;
        instr.read_value = '0;
        cfg.valid = 1'b0;
        cfg.data = '0;
        error_count = 0;
        result_count = 0;
        item_count = 0;
        cycle_count = 0;
        idle_enable = 0;
        hold_results = 0;
        hold_cycles = 0;
        for (int i = 0; i < DATA_DEPTH; i++)
            mdl_mem[i] = '0;
        mdl_pc = '0;
        mdl_frame = '0;
        mdl_halt_pc = 12'd4095;
        repeat (2) @(negedge clk);
        rst_n = 1'b1;

        test_all_opcodes();
        test_corners();
        write_halt_pc(12'd0);
        idle_enable = 1;
        test_random(300);
        write_halt_pc(12'd5);
        test_backpressure();
        test_random(300);
        write_halt_pc(12'd4095);
        idle_enable = 0;
        test_random(280);

        $display("Ran %0d instruction items, checked %0d results, halt pc 0/5/4095.",
                 item_count, result_count);
        if (error_count == 0 && result_queue.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
